[design/ec_scalar_mult_window2_assert.svh]
// Assertion macros for the scalar multiplier
`ifndef EC_SCALAR_MULT_WINDOW2_ASSERT_SVH
`define EC_SCALAR_MULT_WINDOW2_ASSERT_SVH

// same-cycle implication
`define ECSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECSM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/ecsm_pkg.sv]
`timescale 1ns / 1ps
package ecsm_pkg;

    localparam int FIELD_BITS_DEF    = 16;
    localparam int SCALAR_BITS_DEF   = 32;
    localparam int TABLE_ENTRIES_DEF = 4;

    typedef enum logic [0:0] {
        CFG_CURVE_A   = 1'b0,
        CFG_MODULUS_P = 1'b1
    } t_cfg_idx;

    // window width: largest w (up to 4) with 2^w table entries available
    function automatic int win_bits(input int entries);
        int w;
        w = 0;
        while (w < 4 && (2 << w) <= entries) begin
            w++;
        end
        return w;
    endfunction

endpackage

[design/ec_scalar_mult_window2.sv]
// Flow: 3 serial reductions on the divider, then table build and windowed point
// operations, the non-trivial ones each inverting with E Euclid steps on the
// bit-serial multiplier and divider; about 47 point operations for a 32-bit scalar.
// One item at a time: no new input is taken until the result is in the output register.
// Reset (synchronous, active low) clears control and sets curve_a = 3, modulus_p = 7.
`timescale 1ns / 1ps
module ec_scalar_mult_window2 #(
    parameter int FIELD_BITS    = ecsm_pkg::FIELD_BITS_DEF,
    parameter int SCALAR_BITS   = ecsm_pkg::SCALAR_BITS_DEF,
    parameter int TABLE_ENTRIES = ecsm_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  ecsm_pkg::t_cfg_idx     i_cfg_idx,
    input  logic [FIELD_BITS-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [FIELD_BITS-1:0]  i_point_x,
    input  logic [FIELD_BITS-1:0]  i_point_y,
    input  logic                   i_point_at_infinity,
    input  logic [SCALAR_BITS-1:0] i_scalar,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [FIELD_BITS-1:0]  o_result_x,
    output logic [FIELD_BITS-1:0]  o_result_y,
    output logic                   o_result_at_infinity
);
    import ecsm_pkg::*;
    `include "ec_scalar_mult_window2_assert.svh"

    localparam int W    = FIELD_BITS;
    localparam int WW   = win_bits(TABLE_ENTRIES);
    localparam int NT   = 2 ** WW;
    localparam int NWIN = (SCALAR_BITS + WW - 1) / WW;
    localparam int KB   = NWIN * WW;
    localparam int NCW  = $clog2(NWIN + 1);
    localparam int JW   = (WW > 1) ? $clog2(WW) : 1;

    typedef enum logic [19:0] {
        S_IDLE    = 20'd1,
        S_RED_X   = 20'd2,
        S_RED_Y   = 20'd4,
        S_RED_A   = 20'd8,
        S_BUILD   = 20'd16,
        S_SKIP    = 20'd32,
        S_WIN     = 20'd64,
        S_PA      = 20'd128,
        S_PA_SQ   = 20'd256,
        S_PA_N3   = 20'd512,
        S_PA_NA   = 20'd1024,
        S_INV     = 20'd2048,
        S_INV_DIV = 20'd4096,
        S_INV_MUL = 20'd8192,
        S_LAM     = 20'd16384,
        S_RX      = 20'd32768,
        S_RX2     = 20'd65536,
        S_RY      = 20'd131072,
        S_RET     = 20'd262144,
        S_DONE    = 20'd524288
    } t_state;

    typedef enum logic [1:0] {
        PH_BUILD = 2'd0,
        PH_DBL   = 2'd1,
        PH_ADD   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [W-1:0] x;
        logic [W-1:0] y;
        logic         inf;
    } t_point;

    function automatic logic [W-1:0] f_add(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] f_sub(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] m);
        logic [W:0] s;
        s = {1'b0, u} + {1'b0, m} - {1'b0, v};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[W-1:0];
    endfunction

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [W-1:0]  r_cfg_a, r_cfg_p;
    logic [W-1:0]  r_bx, n_bx, r_by, n_by, r_ra, n_ra;
    t_point        r_acc, n_acc, r_p, n_p, r_q, n_q;
    logic [KB-1:0] r_k, n_k;
    logic [NCW-1:0] r_wcnt, n_wcnt;
    logic [WW:0]   r_i, n_i;
    logic [JW-1:0] r_j, n_j;
    logic [W-1:0]  r_num, n_num, r_s, n_s, r_lam, n_lam, r_rx, n_rx;
    logic [W-1:0]  r_r0, n_r0, r_r1, n_r1, r_t0, n_t0, r_t1, n_t1, r_rem, n_rem;
    t_point        r_out, n_out;
    logic          r_ovalid, n_ovalid;
    t_point        r_tab [NT];

    logic          w_tab_we;
    logic [WW-1:0] w_tab_idx;
    t_point        w_tab_wd;
    logic [WW-1:0] w_top;
    t_point        w_tab_rd;

    logic          w_mul_start, w_mul_done;
    logic [W-1:0]  w_mul_u, w_mul_v, w_mul_prod;
    logic          w_div_start, w_div_done;
    logic [W-1:0]  w_div_n, w_div_d, w_quot, w_drem;

    logic [W-1:0]  w_negqy;
    logic          w_accept;

    assign w_accept = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign w_top    = r_k[KB-1 -: WW];
    assign w_tab_rd = r_tab[w_top];
    assign w_negqy  = f_sub('0, r_q.y, r_cfg_p);

    ecsm_mmul #(.W(W)) u_mmul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_mul_start),
        .i_u    (w_mul_u),
        .i_v    (w_mul_v),
        .i_m    (r_cfg_p),
        .o_done (w_mul_done),
        .o_prod (w_mul_prod)
    );

    ecsm_div #(.W(W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_n    (w_div_n),
        .i_d    (w_div_d),
        .o_done (w_div_done),
        .o_quot (w_quot),
        .o_rem  (w_drem)
    );

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_bx     = r_bx;
        n_by     = r_by;
        n_ra     = r_ra;
        n_acc    = r_acc;
        n_p      = r_p;
        n_q      = r_q;
        n_k      = r_k;
        n_wcnt   = r_wcnt;
        n_i      = r_i;
        n_j      = r_j;
        n_num    = r_num;
        n_s      = r_s;
        n_lam    = r_lam;
        n_rx     = r_rx;
        n_r0     = r_r0;
        n_r1     = r_r1;
        n_t0     = r_t0;
        n_t1     = r_t1;
        n_rem    = r_rem;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_ready;
        w_tab_we  = 1'b0;
        w_tab_idx = '0;
        w_tab_wd  = r_acc;
        w_mul_start = 1'b0;
        w_mul_u     = r_num;
        w_mul_v     = r_t0;
        w_div_start = 1'b0;
        w_div_n     = r_bx;
        w_div_d     = r_cfg_p;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_bx   = i_point_x;
                    n_by   = i_point_y;
                    n_k    = KB'(i_scalar);
                    n_wcnt = NCW'(NWIN);
                    if (r_cfg_p < W'(2) || i_scalar == '0 || i_point_at_infinity) begin
                        n_acc   = '0;
                        n_acc.inf = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        w_div_start = 1'b1;
                        w_div_n     = i_point_x;
                        n_state     = S_RED_X;
                    end
                end
            end
            S_RED_X: begin
                if (w_div_done) begin
                    n_bx        = w_drem;
                    w_tab_we    = 1'b1;
                    w_tab_idx   = '0;
                    w_tab_wd    = '0;
                    w_tab_wd.inf = 1'b1;
                    w_div_start = 1'b1;
                    w_div_n     = r_by;
                    n_state     = S_RED_Y;
                end
            end
            S_RED_Y: begin
                if (w_div_done) begin
                    n_by        = w_drem;
                    w_div_start = 1'b1;
                    w_div_n     = r_cfg_a;
                    n_state     = S_RED_A;
                end
            end
            S_RED_A: begin
                if (w_div_done) begin
                    n_ra      = w_drem;
                    n_acc     = '{x: r_bx, y: r_by, inf: 1'b0};
                    w_tab_we  = 1'b1;
                    w_tab_idx = WW'(1);
                    w_tab_wd  = '{x: r_bx, y: r_by, inf: 1'b0};
                    n_i       = (WW + 1)'(2);
                    n_state   = S_BUILD;
                end
            end
            S_BUILD: begin
                if (r_i > (WW + 1)'(NT - 1)) begin
                    n_state = S_SKIP;
                end else begin
                    n_p     = '{x: r_bx, y: r_by, inf: 1'b0};
                    n_q     = r_acc;
                    n_phase = PH_BUILD;
                    n_state = S_PA;
                end
            end
            S_SKIP: begin
                if (r_wcnt > NCW'(1) && w_top == '0) begin
                    n_k    = r_k << WW;
                    n_wcnt = r_wcnt - 1'b1;
                end else begin
                    n_acc   = w_tab_rd;
                    n_k     = r_k << WW;
                    n_wcnt  = r_wcnt - 1'b1;
                    n_state = S_WIN;
                end
            end
            S_WIN: begin
                if (r_wcnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = '0;
                    n_p     = r_acc;
                    n_q     = r_acc;
                    n_phase = PH_DBL;
                    n_state = S_PA;
                end
            end
            S_PA: begin
                if (r_p.inf) begin
                    n_acc   = r_q;
                    n_state = S_RET;
                end else if (r_q.inf) begin
                    n_acc   = r_p;
                    n_state = S_RET;
                end else if (r_p.x == r_q.x && r_p.y == w_negqy) begin
                    n_acc   = '0;
                    n_acc.inf = 1'b1;
                    n_state = S_RET;
                end else if (r_p.x != r_q.x) begin
                    n_num   = f_sub(r_p.y, r_q.y, r_cfg_p);
                    n_r0    = r_cfg_p;
                    n_r1    = f_sub(r_p.x, r_q.x, r_cfg_p);
                    n_t0    = '0;
                    n_t1    = W'(1);
                    n_state = S_INV;
                end else begin
                    w_mul_start = 1'b1;
                    w_mul_u     = r_p.x;
                    w_mul_v     = r_p.x;
                    n_state     = S_PA_SQ;
                end
            end
            S_PA_SQ: begin
                if (w_mul_done) begin
                    n_s     = w_mul_prod;
                    n_num   = f_add(w_mul_prod, w_mul_prod, r_cfg_p);
                    n_state = S_PA_N3;
                end
            end
            S_PA_N3: begin
                n_num   = f_add(r_num, r_s, r_cfg_p);
                n_state = S_PA_NA;
            end
            S_PA_NA: begin
                n_num   = f_add(r_num, r_ra, r_cfg_p);
                n_r0    = r_cfg_p;
                n_r1    = f_add(r_p.y, r_p.y, r_cfg_p);
                n_t0    = '0;
                n_t1    = W'(1);
                n_state = S_INV;
            end
            S_INV: begin
                if (r_r1 == '0) begin
                    w_mul_start = 1'b1;
                    w_mul_u     = r_num;
                    w_mul_v     = r_t0;
                    n_state     = S_LAM;
                end else begin
                    w_div_start = 1'b1;
                    w_div_n     = r_r0;
                    w_div_d     = r_r1;
                    n_state     = S_INV_DIV;
                end
            end
            S_INV_DIV: begin
                if (w_div_done) begin
                    n_rem       = w_drem;
                    w_mul_start = 1'b1;
                    w_mul_u     = r_t1;
                    w_mul_v     = w_quot;
                    n_state     = S_INV_MUL;
                end
            end
            S_INV_MUL: begin
                if (w_mul_done) begin
                    n_t1    = f_sub(r_t0, w_mul_prod, r_cfg_p);
                    n_t0    = r_t1;
                    n_r0    = r_r1;
                    n_r1    = r_rem;
                    n_state = S_INV;
                end
            end
            S_LAM: begin
                if (w_mul_done) begin
                    n_lam       = w_mul_prod;
                    w_mul_start = 1'b1;
                    w_mul_u     = w_mul_prod;
                    w_mul_v     = w_mul_prod;
                    n_state     = S_RX;
                end
            end
            S_RX: begin
                if (w_mul_done) begin
                    n_rx    = f_sub(f_sub(w_mul_prod, r_p.x, r_cfg_p), r_q.x, r_cfg_p);
                    n_state = S_RX2;
                end
            end
            S_RX2: begin
                w_mul_start = 1'b1;
                w_mul_u     = r_lam;
                w_mul_v     = f_sub(r_p.x, r_rx, r_cfg_p);
                n_state     = S_RY;
            end
            S_RY: begin
                if (w_mul_done) begin
                    n_acc   = '{x: r_rx, y: f_sub(w_mul_prod, r_p.y, r_cfg_p), inf: 1'b0};
                    n_state = S_RET;
                end
            end
            S_RET: begin
                case (r_phase)
                    PH_BUILD: begin
                        w_tab_we  = 1'b1;
                        w_tab_idx = r_i[WW-1:0];
                        w_tab_wd  = r_acc;
                        n_i       = r_i + 1'b1;
                        n_state   = S_BUILD;
                    end
                    PH_DBL: begin
                        n_p = r_acc;
                        if (r_j == JW'(WW - 1)) begin
                            n_q     = w_tab_rd;
                            n_phase = PH_ADD;
                        end else begin
                            n_q = r_acc;
                            n_j = r_j + 1'b1;
                        end
                        n_state = S_PA;
                    end
                    default: begin
                        n_k     = r_k << WW;
                        n_wcnt  = r_wcnt - 1'b1;
                        n_state = S_WIN;
                    end
                endcase
            end
            S_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_out    = r_acc.inf ? t_point'{x: '0, y: '0, inf: 1'b1} : r_acc;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_BUILD;
            r_ovalid <= 1'b0;
            r_cfg_a  <= W'(3);
            r_cfg_p  <= W'(7);
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_CURVE_A:   r_cfg_a <= i_cfg_data;
                    CFG_MODULUS_P: r_cfg_p <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bx   <= n_bx;
        r_by   <= n_by;
        r_ra   <= n_ra;
        r_acc  <= n_acc;
        r_p    <= n_p;
        r_q    <= n_q;
        r_k    <= n_k;
        r_wcnt <= n_wcnt;
        r_i    <= n_i;
        r_j    <= n_j;
        r_num  <= n_num;
        r_s    <= n_s;
        r_lam  <= n_lam;
        r_rx   <= n_rx;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_t0   <= n_t0;
        r_t1   <= n_t1;
        r_rem  <= n_rem;
        r_out  <= n_out;
        if (w_tab_we) begin
            r_tab[w_tab_idx] <= w_tab_wd;
        end
    end

    assign o_valid              = r_ovalid;
    assign o_result_x           = r_out.x;
    assign o_result_y           = r_out.y;
    assign o_result_at_infinity = r_out.inf;

    `ECSM_ASSERT_IMP(a_inf_zero, i_clk, i_rst_n, o_valid && o_result_at_infinity, o_result_x == '0 && o_result_y == '0, "infinity result with nonzero coordinates")
    `ECSM_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, r_state != S_IDLE, "idle right after input transfer")
    `ECSM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_state == S_DONE && o_valid && !i_ready, r_state == S_DONE && o_valid, "pending result overwritten")

endmodule

[design/ecsm_mmul.sv]
`timescale 1ns / 1ps
module ecsm_mmul #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_u,
    input  logic [W-1:0] i_v,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_prod
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_acc, r_u, r_v, r_m;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_t1, w_t2;

    // acc = 2*acc + bit*u mod m, msb of v first
    always_comb begin
        w_t1 = {r_acc, 1'b0};
        if (w_t1 >= {1'b0, r_m}) begin
            w_t1 = w_t1 - {1'b0, r_m};
        end
        w_t2 = w_t1 + (r_v[W-1] ? {1'b0, r_u} : '0);
        if (w_t2 >= {1'b0, r_m}) begin
            w_t2 = w_t2 - {1'b0, r_m};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_u   <= i_u;
            r_v   <= i_v;
            r_m   <= i_m;
        end else if (r_busy) begin
            r_acc <= w_t2[W-1:0];
            r_v   <= {r_v[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[design/ecsm_div.sv]
`timescale 1ns / 1ps
module ecsm_div #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_n,
    input  logic [W-1:0] i_d,
    output logic         o_done,
    output logic [W-1:0] o_quot,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_n, r_d, r_q, r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [W:0]    w_t;
    logic [W-1:0]  w_rem;
    logic          w_qbit;

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_t = {r_rem, r_n[W-1]};
        if (w_t >= {1'b0, r_d}) begin
            w_t    = w_t - {1'b0, r_d};
            w_qbit = 1'b1;
        end else begin
            w_qbit = 1'b0;
        end
        w_rem = w_t[W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_d   <= i_d;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[W-2:0], 1'b0};
            r_q   <= {r_q[W-2:0], w_qbit};
            r_rem <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule
